// ===== rtl/trsm_pkg.sv =====
`default_nettype none

package trsm_pkg;

    typedef logic [1:0] t_trit;
    typedef logic [1:0] t_dim;
    typedef logic [7:0] t_count;

    // Role codes
    localparam t_trit ROLE_CTRL  = 2'd0;
    localparam t_trit ROLE_DATA  = 2'd1;
    localparam t_trit ROLE_COORD = 2'd2;

    // Combine modes held in the mode trit of the control dimension.
    localparam t_trit MODE_MAX   = 2'd0;
    localparam t_trit MODE_MIN   = 2'd1;
    localparam t_trit MODE_FIRST = 2'd2;

    // Command codes
    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam int unsigned NUM_DIMS = 3;
    localparam logic [1:0] NO_DIM = 2'd3;

    // A step reassigns roles once the counter sum reaches this value.
    localparam logic [9:0] STAB_SUM_MIN = 10'd18;
    localparam t_count     STAB_HIGH    = 8'd3;

    typedef struct packed {
        logic   cmd;
        t_dim   dim_index;
        t_trit  load_data;
        t_trit  load_mode;
        t_trit  load_route;
        t_trit  load_role;
        t_count load_stability;
    } t_in_word;

    typedef struct packed {
        logic [5:0] roles_in;
        logic [5:0] roles_out;
        logic       roles_moved;
        t_trit      pair_zero_one;
        t_trit      pair_one_two;
        t_trit      pair_two_zero;
        t_trit      emergent_data;
        t_trit      emergent_mode;
        t_trit      emergent_route;
    } t_out_word;

    function automatic t_trit sat_trit(input t_trit x);
        return (x == 2'd3) ? 2'd2 : x;
    endfunction

    // Spread of three trits: 0 all equal, 1 two equal, 2 all distinct.
    function automatic t_trit ent3(input t_trit a, input t_trit b, input t_trit c);
        if (a == b && b == c) begin
            return 2'd0;
        end
        if (a == b || a == c || b == c) begin
            return 2'd1;
        end
        return 2'd2;
    endfunction

    function automatic t_trit maj3(input t_trit a, input t_trit b, input t_trit c);
        if (a == b || a == c) begin
            return a;
        end
        if (b == c) begin
            return b;
        end
        return 2'd0;
    endfunction

    function automatic t_trit tmax(input t_trit a, input t_trit b);
        return (a >= b) ? a : b;
    endfunction

    function automatic t_trit tmin(input t_trit a, input t_trit b);
        return (a <= b) ? a : b;
    endfunction

    // Mode 0 takes the maximum, mode 1 the minimum, otherwise the first operand.
    function automatic t_trit combine(input t_trit a, input t_trit b, input t_trit mode);
        case (mode)
            MODE_MAX: return tmax(a, b);
            MODE_MIN: return tmin(a, b);
            default:  return a;
        endcase
    endfunction

    // Index of the smallest of three values, lowest index on ties.
    function automatic t_dim pick_min3(input t_trit e0, input t_trit e1, input t_trit e2);
        if (e0 <= e1 && e0 <= e2) begin
            return 2'd0;
        end
        return (e1 <= e2) ? 2'd1 : 2'd2;
    endfunction

    function automatic t_dim idx_next(input t_dim i);
        case (i)
            2'd0:    return 2'd1;
            2'd1:    return 2'd2;
            default: return 2'd0;
        endcase
    endfunction

    function automatic t_dim idx_prev(input t_dim i);
        case (i)
            2'd0:    return 2'd2;
            2'd1:    return 2'd0;
            default: return 2'd1;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/trsm_if.sv =====
`default_nettype none

interface trsm_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [1:0] dim_index;
    logic [1:0] load_data;
    logic [1:0] load_mode;
    logic [1:0] load_route;
    logic [1:0] load_role;
    logic [7:0] load_stability;

    modport source (
        output valid, cmd, dim_index, load_data, load_mode, load_route, load_role,
               load_stability,
        input  ready
    );
    modport sink (
        input  valid, cmd, dim_index, load_data, load_mode, load_route, load_role,
               load_stability,
        output ready
    );
endinterface

interface trsm_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] roles_in;
    logic [5:0] roles_out;
    logic       roles_moved;
    logic [1:0] pair_zero_one;
    logic [1:0] pair_one_two;
    logic [1:0] pair_two_zero;
    logic [1:0] emergent_data;
    logic [1:0] emergent_mode;
    logic [1:0] emergent_route;

    modport source (
        output valid, roles_in, roles_out, roles_moved, pair_zero_one, pair_one_two,
               pair_two_zero, emergent_data, emergent_mode, emergent_route,
        input  ready
    );
    modport sink (
        input  valid, roles_in, roles_out, roles_moved, pair_zero_one, pair_one_two,
               pair_two_zero, emergent_data, emergent_mode, emergent_route,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/ternary_role_step_machine.sv =====
`default_nettype none

// Three-dimension ternary role machine. Each dimension stores a data, a mode
// and a route trit, a role (control, data or coordinator) and an 8-bit
// stability counter. A load word writes one dimension, or none for index three,
// and returns nothing; a step word measures the spread of each field, reassigns
// the roles when the fields are unsettled or the counters have run long enough,
// combines the active pair, updates the trits under the roles and returns one
// result word. Every word is held in the input register until it can retire,
// and a step is evaluated in full in the cycle it leaves that register, so the
// stored state and the output register are written at the same edge. The block
// takes one word per cycle when the output side keeps up; a step result is
// written to the output register as its word leaves the input register. The
// rate is set by the read-modify-write of the dimension state, which the next
// step reads. A result waiting in the output register holds back a step in the
// input register but not a load, and while a step waits there the input is not
// ready. Counters saturate at the smaller of STABILITY_LIMIT and 255.
module ternary_role_step_machine
    import trsm_pkg::*;
#(
    parameter int STABILITY_LIMIT = 255
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    trsm_in_if.sink     i_in,
    trsm_out_if.source  o_out
);

    localparam t_count STAB_CAP = (STABILITY_LIMIT < 255) ? t_count'(STABILITY_LIMIT)
                                                          : 8'd255;

    // Input stage and output stage.
    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;

    // Dimension state.
    t_trit  r_data  [NUM_DIMS];
    t_trit  r_mode  [NUM_DIMS];
    t_trit  r_route [NUM_DIMS];
    t_trit  r_role  [NUM_DIMS];
    t_count r_stab  [NUM_DIMS];

    t_trit  n_data  [NUM_DIMS];
    t_trit  n_mode  [NUM_DIMS];
    t_trit  n_route [NUM_DIMS];
    t_trit  n_role  [NUM_DIMS];
    t_count n_stab  [NUM_DIMS];

    // Step results.
    t_trit     s_data  [NUM_DIMS];
    t_trit     s_mode  [NUM_DIMS];
    t_trit     s_route [NUM_DIMS];
    t_trit     s_role  [NUM_DIMS];
    t_count    s_stab  [NUM_DIMS];
    t_out_word s_out;

    logic     out_free;
    logic     advance;
    logic     in_accept;
    t_in_word in_word;

    // An output slot is needed only by step words; loads retire freely.
    assign out_free  = !r_out_valid || o_out.ready;
    assign advance   = r_in_valid && ((r_in.cmd == CMD_LOAD) || out_free);
    assign i_in.ready = !r_in_valid || advance;
    assign in_accept = i_in.valid && i_in.ready;

    assign in_word = '{
        cmd:            i_in.cmd,
        dim_index:      i_in.dim_index,
        load_data:      i_in.load_data,
        load_mode:      i_in.load_mode,
        load_route:     i_in.load_route,
        load_role:      i_in.load_role,
        load_stability: i_in.load_stability
    };

    // One complete step, evaluated from the stored state.
    always_comb begin
        t_trit      e_d, e_m, e_r;
        logic       stable;
        logic [9:0] sum;
        logic       do_reassign;
        logic [2:0] sc [NUM_DIMS];
        logic [2:0] sd [NUM_DIMS];
        t_dim       bc, bd, nx;
        logic [5:0] old_pack, new_pack;
        logic       changed;
        logic       ctrl_ok, dat_ok, crd_ok;
        t_dim       ctrl_ix, dat_ix, crd_ix;
        t_trit      mode_sel, ap;
        t_trit      pr [NUM_DIMS];
        t_trit      ma, mb, rr;
        t_trit      re0, re1, re2;

        s_data  = r_data;
        s_mode  = r_mode;
        s_route = r_route;

        e_d = ent3(r_data[0], r_data[1], r_data[2]);
        e_m = ent3(r_mode[0], r_mode[1], r_mode[2]);
        e_r = ent3(r_route[0], r_route[1], r_route[2]);
        stable = (e_d != 2'd2) && (e_m != 2'd2) && (e_r != 2'd2);
        sum = 10'(r_stab[0]) + 10'(r_stab[1]) + 10'(r_stab[2]);
        do_reassign = !stable || (sum >= STAB_SUM_MIN);

        // Scores for the control and data roles; the coordinator takes what is left.
        for (int i = 0; i < NUM_DIMS; i++) begin
            nx = idx_next(t_dim'(i));
            sc[i] = ((r_mode[i] == r_mode[nx]) ? 3'd3 : 3'd0)
                  + (!stable ? 3'd2 : 3'd0)
                  + ((e_d == 2'd2) ? 3'd2 : 3'd0);
            sd[i] = ((r_data[i] != r_data[nx]) ? 3'd3 : 3'd0)
                  + ((e_m == 2'd0) ? 3'd3 : 3'd0)
                  + ((r_stab[i] > STAB_HIGH) ? 3'd1 : 3'd0);
        end
        bc = 2'd0;
        for (int i = 1; i < NUM_DIMS; i++) begin
            if (sc[i] > sc[bc]) begin
                bc = t_dim'(i);
            end
        end
        bd = (bc == 2'd0) ? 2'd1 : 2'd0;
        for (int i = 0; i < NUM_DIMS; i++) begin
            if (t_dim'(i) != bc && sd[i] > sd[bd]) begin
                bd = t_dim'(i);
            end
        end
        for (int i = 0; i < NUM_DIMS; i++) begin
            if (!do_reassign) begin
                s_role[i] = r_role[i];
            end else if (t_dim'(i) == bc) begin
                s_role[i] = ROLE_CTRL;
            end else if (t_dim'(i) == bd) begin
                s_role[i] = ROLE_DATA;
            end else begin
                s_role[i] = ROLE_COORD;
            end
        end
        old_pack = {r_role[2], r_role[1], r_role[0]};
        new_pack = {s_role[2], s_role[1], s_role[0]};
        changed  = old_pack != new_pack;

        // With duplicate roles the lowest dimension acts, so scan downward.
        ctrl_ok = 1'b0; dat_ok = 1'b0; crd_ok = 1'b0;
        ctrl_ix = 2'd0; dat_ix = 2'd0; crd_ix = 2'd0;
        for (int i = NUM_DIMS - 1; i >= 0; i--) begin
            if (s_role[i] == ROLE_CTRL) begin
                ctrl_ok = 1'b1;
                ctrl_ix = t_dim'(i);
            end
            if (s_role[i] == ROLE_DATA) begin
                dat_ok = 1'b1;
                dat_ix = t_dim'(i);
            end
            if (s_role[i] == ROLE_COORD) begin
                crd_ok = 1'b1;
                crd_ix = t_dim'(i);
            end
        end

        mode_sel = ctrl_ok ? r_mode[ctrl_ix] : MODE_FIRST;
        ap       = crd_ok ? r_route[crd_ix] : 2'd0;
        pr[0] = (ap == 2'd0) ? combine(r_data[0], r_data[1], mode_sel) : r_data[0];
        pr[1] = (ap == 2'd1) ? combine(r_data[1], r_data[2], mode_sel) : r_data[1];
        pr[2] = (ap == 2'd2) ? combine(r_data[2], r_data[0], mode_sel) : r_data[2];

        // Mode update by the control dimension.
        ma = r_mode[idx_prev(ctrl_ix)];
        mb = r_mode[idx_next(ctrl_ix)];
        rr = pr[idx_prev(ctrl_ix)];
        if (ctrl_ok) begin
            s_mode[ctrl_ix] = (rr == tmin(ma, mb)) ? MODE_MIN
                            : ((rr == tmax(ma, mb)) ? MODE_MAX : MODE_FIRST);
        end

        // Data update by the data dimension.
        if (dat_ok) begin
            s_data[dat_ix] = pr[dat_ix];
        end

        // Route update by the coordinator, using the data trits just written.
        re0 = ent3(s_data[0], s_data[1], pr[0]);
        re1 = ent3(s_data[1], s_data[2], pr[1]);
        re2 = ent3(s_data[2], s_data[0], pr[2]);
        if (crd_ok) begin
            s_route[crd_ix] = pick_min3(re0, re1, re2);
        end

        for (int i = 0; i < NUM_DIMS; i++) begin
            if (changed) begin
                s_stab[i] = 8'd0;
            end else if (r_stab[i] < STAB_CAP) begin
                s_stab[i] = r_stab[i] + 8'd1;
            end else begin
                s_stab[i] = r_stab[i];
            end
        end

        s_out.roles_in       = old_pack;
        s_out.roles_out      = new_pack;
        s_out.roles_moved    = changed;
        s_out.pair_zero_one  = pr[0];
        s_out.pair_one_two   = pr[1];
        s_out.pair_two_zero  = pr[2];
        s_out.emergent_data  = maj3(pr[0], pr[1], pr[2]);
        s_out.emergent_mode  = (ent3(pr[0], pr[1], pr[2]) == 2'd2) ? 2'd2
                             : maj3(s_mode[0], s_mode[1], s_mode[2]);
        s_out.emergent_route = pick_min3({1'b0, s_data[0] != s_data[1]},
                                         {1'b0, s_data[1] != s_data[2]},
                                         {1'b0, s_data[2] != s_data[0]});
    end

    // Next state: a load writes at most one dimension, a step takes the step results.
    always_comb begin
        n_data  = r_data;
        n_mode  = r_mode;
        n_route = r_route;
        n_role  = r_role;
        n_stab  = r_stab;
        if (advance) begin
            if (r_in.cmd == CMD_LOAD) begin
                for (int i = 0; i < NUM_DIMS; i++) begin
                    if (r_in.dim_index != NO_DIM && r_in.dim_index == t_dim'(i)) begin
                        n_data[i]  = sat_trit(r_in.load_data);
                        n_mode[i]  = sat_trit(r_in.load_mode);
                        n_route[i] = sat_trit(r_in.load_route);
                        n_role[i]  = sat_trit(r_in.load_role);
                        n_stab[i]  = r_in.load_stability;
                    end
                end
            end else begin
                n_data  = s_data;
                n_mode  = s_mode;
                n_route = s_route;
                n_role  = s_role;
                n_stab  = s_stab;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_DIMS; i++) begin
                r_data[i]  <= 2'd0;
                r_mode[i]  <= 2'd0;
                r_route[i] <= 2'd0;
                r_role[i]  <= t_trit'(i);
                r_stab[i]  <= 8'd0;
            end
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance && r_in.cmd == CMD_STEP) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_data  <= n_data;
            r_mode  <= n_mode;
            r_route <= n_route;
            r_role  <= n_role;
            r_stab  <= n_stab;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= in_word;
        end
        if (advance && r_in.cmd == CMD_STEP) begin
            r_out <= s_out;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.roles_in       = r_out.roles_in;
    assign o_out.roles_out      = r_out.roles_out;
    assign o_out.roles_moved    = r_out.roles_moved;
    assign o_out.pair_zero_one  = r_out.pair_zero_one;
    assign o_out.pair_one_two   = r_out.pair_one_two;
    assign o_out.pair_two_zero  = r_out.pair_two_zero;
    assign o_out.emergent_data  = r_out.emergent_data;
    assign o_out.emergent_mode  = r_out.emergent_mode;
    assign o_out.emergent_route = r_out.emergent_route;

endmodule

`default_nettype wire

// ===== rtl/trsm_checker.sv =====
`default_nettype none

module trsm_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [5:0] i_roles_in,
    input wire logic [5:0] i_roles_out,
    input wire logic       i_roles_moved
);

    // A stalled result word stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_roles_out)
            && $stable(i_roles_in) && $stable(i_roles_moved))
        else $error("result word changed while stalled");

    // The change flag matches the two role packings.
    a_changed_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_roles_moved == (i_roles_in != i_roles_out)))
        else $error("roles_moved disagrees with the role fields");

    // A change only comes from reassignment, which hands out three distinct roles.
    a_changed_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_roles_moved |->
            (i_roles_out[1:0] != i_roles_out[3:2]) && (i_roles_out[1:0] != i_roles_out[5:4])
            && (i_roles_out[3:2] != i_roles_out[5:4]))
        else $error("changed roles are not a permutation");

    // Roles are saturated on load, so no role code reads as three.
    a_role_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_roles_in[1:0] != 2'd3) && (i_roles_in[3:2] != 2'd3)
            && (i_roles_in[5:4] != 2'd3) && (i_roles_out[1:0] != 2'd3)
            && (i_roles_out[3:2] != 2'd3) && (i_roles_out[5:4] != 2'd3))
        else $error("role code out of range");

endmodule

bind ternary_role_step_machine trsm_checker u_trsm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_roles_in    (o_out.roles_in),
    .i_roles_out   (o_out.roles_out),
    .i_roles_moved (o_out.roles_moved)
);

`default_nettype wire

// ===== tb/trsm_step_checker.sv =====
`timescale 1ns / 1ps

module trsm_step_checker
    import trsm_pkg::*;
#(
    parameter int STAB_CAP = 255
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    trsm_in_if        i_in_mon,
    trsm_out_if       i_out_mon,
    output int        o_fail_count,
    output int        o_pending
);

    t_trit     dim_data  [3];
    t_trit     dim_mode  [3];
    t_trit     dim_route [3];
    t_trit     dim_role  [3];
    t_count    dim_stab  [3];
    t_out_word step_results_due [$];
    int        mismatch_total = 0;
    int        due_count      = 0;

    assign o_fail_count = mismatch_total;
    assign o_pending    = due_count;

    // Spread of three trits: 0 when all agree, 1 when two agree, 2 when all differ.
    function automatic int spread_of(input t_trit a, input t_trit b, input t_trit c);
        int diffs;
        diffs = int'(a != b) + int'(a != c) + int'(b != c);
        if (diffs == 0) begin
            return 0;
        end
        return (diffs == 2) ? 1 : 2;
    endfunction

    function automatic t_trit majority_of(input t_trit a, input t_trit b, input t_trit c);
        if (b == c) begin
            return b;
        end
        return (a == b || a == c) ? a : 2'd0;
    endfunction

    function automatic int lowest_min_index(input int e0, input int e1, input int e2);
        if (e0 <= e1 && e0 <= e2) begin
            return 0;
        end
        return (e1 <= e2) ? 1 : 2;
    endfunction

    function automatic t_trit merge_pair(input t_trit a, input t_trit b, input t_trit op);
        case (op)
            MODE_MAX: begin
                return (a > b) ? a : b;
            end
            MODE_MIN: begin
                return (a < b) ? a : b;
            end
            default: begin
                return a;
            end
        endcase
    endfunction

    function automatic t_trit clamp_trit(input t_trit x);
        return (x > 2'd2) ? 2'd2 : x;
    endfunction

    function automatic int first_with_role(input t_trit role);
        for (int i = 0; i < 3; i++) begin
            if (dim_role[i] == role) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic logic [5:0] packed_roles();
        return {dim_role[2], dim_role[1], dim_role[0]};
    endfunction

    function automatic void restore_reset_state();
        for (int i = 0; i < 3; i++) begin
            dim_data[i]  = 2'd0;
            dim_mode[i]  = 2'd0;
            dim_route[i] = 2'd0;
            dim_role[i]  = t_trit'(i);
            dim_stab[i]  = '0;
        end
    endfunction

    // Greedy choice: best control score first, then best data score among the rest.
    function automatic void reassign_roles(input int spr_data, input int spr_mode,
                                           input bit settled);
        int ctl_score [3];
        int dat_score [3];
        int pick_ctl;
        int pick_dat;
        int nxt;
        for (int i = 0; i < 3; i++) begin
            nxt = (i + 1) % 3;
            ctl_score[i] = ((dim_mode[i] == dim_mode[nxt]) ? 3 : 0) + (settled ? 0 : 2)
                         + ((spr_data > 1) ? 2 : 0);
            dat_score[i] = ((dim_data[i] != dim_data[nxt]) ? 3 : 0)
                         + ((spr_mode == 0) ? 3 : 0) + ((dim_stab[i] > STAB_HIGH) ? 1 : 0);
        end
        pick_ctl = 0;
        for (int i = 1; i < 3; i++) begin
            if (ctl_score[i] > ctl_score[pick_ctl]) begin
                pick_ctl = i;
            end
        end
        pick_dat = (pick_ctl == 0) ? 1 : 0;
        for (int i = 0; i < 3; i++) begin
            if (i != pick_ctl && dat_score[i] > dat_score[pick_dat]) begin
                pick_dat = i;
            end
        end
        for (int i = 0; i < 3; i++) begin
            dim_role[i] = (i == pick_ctl) ? ROLE_CTRL
                        : ((i == pick_dat) ? ROLE_DATA : ROLE_COORD);
        end
    endfunction

    function automatic void apply_load(input t_in_word w);
        if (w.dim_index != NO_DIM) begin
            dim_data[w.dim_index]  = clamp_trit(w.load_data);
            dim_mode[w.dim_index]  = clamp_trit(w.load_mode);
            dim_route[w.dim_index] = clamp_trit(w.load_route);
            dim_role[w.dim_index]  = clamp_trit(w.load_role);
            dim_stab[w.dim_index]  = w.load_stability;
        end
    endfunction

    function automatic t_out_word compute_step_result();
        t_out_word  res;
        logic [5:0] roles_before;
        int         spr_d;
        int         spr_m;
        int         spr_r;
        int         stab_sum;
        int         ctl_dim;
        int         crd_dim;
        int         dat_dim;
        bit         settled;
        bit         changed;
        t_trit      op_mode;
        t_trit      live_pair;
        t_trit      pr [3];
        t_trit      lo;
        t_trit      hi;
        t_trit      ref_r;

        roles_before = packed_roles();
        spr_d = spread_of(dim_data[0], dim_data[1], dim_data[2]);
        spr_m = spread_of(dim_mode[0], dim_mode[1], dim_mode[2]);
        spr_r = spread_of(dim_route[0], dim_route[1], dim_route[2]);
        settled = (spr_d <= 1) && (spr_m <= 1) && (spr_r <= 1);
        stab_sum = int'(dim_stab[0]) + int'(dim_stab[1]) + int'(dim_stab[2]);
        if (!settled || stab_sum >= int'(STAB_SUM_MIN)) begin
            reassign_roles(spr_d, spr_m, settled);
        end
        changed = (packed_roles() != roles_before);

        ctl_dim = first_with_role(ROLE_CTRL);
        crd_dim = first_with_role(ROLE_COORD);
        op_mode = (ctl_dim >= 0) ? dim_mode[ctl_dim] : MODE_FIRST;
        live_pair = (crd_dim >= 0) ? dim_route[crd_dim] : 2'd0;
        pr[0] = (live_pair == 2'd0) ? merge_pair(dim_data[0], dim_data[1], op_mode)
                                    : dim_data[0];
        pr[1] = (live_pair == 2'd1) ? merge_pair(dim_data[1], dim_data[2], op_mode)
                                    : dim_data[1];
        pr[2] = (live_pair == 2'd2) ? merge_pair(dim_data[2], dim_data[0], op_mode)
                                    : dim_data[2];

        if (ctl_dim >= 0) begin
            lo = (dim_mode[(ctl_dim + 2) % 3] < dim_mode[(ctl_dim + 1) % 3])
                 ? dim_mode[(ctl_dim + 2) % 3] : dim_mode[(ctl_dim + 1) % 3];
            hi = (dim_mode[(ctl_dim + 2) % 3] > dim_mode[(ctl_dim + 1) % 3])
                 ? dim_mode[(ctl_dim + 2) % 3] : dim_mode[(ctl_dim + 1) % 3];
            ref_r = pr[(ctl_dim + 2) % 3];
            dim_mode[ctl_dim] = (ref_r == lo) ? MODE_MIN : ((ref_r == hi) ? MODE_MAX : MODE_FIRST);
        end
        dat_dim = first_with_role(ROLE_DATA);
        if (dat_dim >= 0) begin
            dim_data[dat_dim] = pr[dat_dim];
        end
        // The route looks at the data trits after the data update.
        if (crd_dim >= 0) begin
            dim_route[crd_dim] = t_trit'(lowest_min_index(
                spread_of(dim_data[0], dim_data[1], pr[0]),
                spread_of(dim_data[1], dim_data[2], pr[1]),
                spread_of(dim_data[2], dim_data[0], pr[2])));
        end

        res.roles_in       = roles_before;
        res.roles_out      = packed_roles();
        res.roles_moved    = changed;
        res.pair_zero_one  = pr[0];
        res.pair_one_two   = pr[1];
        res.pair_two_zero  = pr[2];
        res.emergent_data  = majority_of(pr[0], pr[1], pr[2]);
        res.emergent_mode  = (spread_of(pr[0], pr[1], pr[2]) == 2)
                             ? 2'd2 : majority_of(dim_mode[0], dim_mode[1], dim_mode[2]);
        res.emergent_route = t_trit'(lowest_min_index(int'(dim_data[0] != dim_data[1]),
                                                      int'(dim_data[1] != dim_data[2]),
                                                      int'(dim_data[2] != dim_data[0])));

        for (int i = 0; i < 3; i++) begin
            if (changed) begin
                dim_stab[i] = '0;
            end else if (int'(dim_stab[i]) < STAB_CAP) begin
                dim_stab[i] = dim_stab[i] + 8'd1;
            end
        end
        return res;
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        t_in_word  taken;
        if (!i_rst_n) begin
            restore_reset_state();
            step_results_due.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (step_results_due.size() == 0) begin
                    $error("result word arrived with no step outstanding");
                    mismatch_total++;
                end else begin
                    want = step_results_due.pop_front();
                    compare_field("roles_in", want.roles_in, i_out_mon.roles_in);
                    compare_field("roles_out", want.roles_out, i_out_mon.roles_out);
                    compare_field("roles_moved", want.roles_moved, i_out_mon.roles_moved);
                    compare_field("pair_zero_one", want.pair_zero_one, i_out_mon.pair_zero_one);
                    compare_field("pair_one_two", want.pair_one_two, i_out_mon.pair_one_two);
                    compare_field("pair_two_zero", want.pair_two_zero, i_out_mon.pair_two_zero);
                    compare_field("emergent_data", want.emergent_data, i_out_mon.emergent_data);
                    compare_field("emergent_mode", want.emergent_mode, i_out_mon.emergent_mode);
                    compare_field("emergent_route", want.emergent_route,
                                  i_out_mon.emergent_route);
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                taken.cmd            = i_in_mon.cmd;
                taken.dim_index      = i_in_mon.dim_index;
                taken.load_data      = i_in_mon.load_data;
                taken.load_mode      = i_in_mon.load_mode;
                taken.load_route     = i_in_mon.load_route;
                taken.load_role      = i_in_mon.load_role;
                taken.load_stability = i_in_mon.load_stability;
                if (taken.cmd == CMD_LOAD) begin
                    apply_load(taken);
                end else begin
                    step_results_due.push_back(compute_step_result());
                end
            end
        end
        due_count = step_results_due.size();
    end

endmodule

// ===== tb/tb_ternary_role_step_machine.sv =====
`timescale 1ns / 1ps

module tb_ternary_role_step_machine;
    import trsm_pkg::*;

    // A limit below 255 lets both counter saturation by stepping and a loaded
    // value above the bound show up.
    localparam int STAB_LIMIT     = 200;
    localparam int STAB_CAP       = (STAB_LIMIT < 255) ? STAB_LIMIT : 255;
    localparam int RANDOM_WORDS   = 1900;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    // Two-bit code three is out of range for trits and roles and must saturate.
    localparam t_trit TRIT_OVER   = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_total;
    int   results_due;
    int   idle_cycles = 0;
    int   burst_left  = 0;
    int   words_sent  = 0;

    trsm_in_if  in_ch ();
    trsm_out_if out_ch ();

    ternary_role_step_machine #(
        .STABILITY_LIMIT(STAB_LIMIT)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // The checker mirrors the block state from the accepted words and scores
    // every result word; it reports how many steps still await a result.
    trsm_step_checker #(
        .STAB_CAP(STAB_CAP)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_mon    (in_ch),
        .i_out_mon   (out_ch),
        .o_fail_count(fail_total),
        .o_pending   (results_due)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The watchdog ends the run once nothing has moved on either channel for
    // too long. Sender gaps and receiver stalls are far shorter than the limit.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_ternary_role_step_machine NOT OK");
                $finish;
            end
        end
    end

    // The receiver switches among four stall patterns: always ready, ready half
    // the time, ready a quarter of the time, and a periodic pattern that is ready
    // for a quarter of each period.
    initial begin
        int stall_kind;
        int stall_left;
        out_ch.ready = 1'b0;
        stall_kind = 0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0) begin
                stall_kind = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 200);
            end
            stall_left--;
            case (stall_kind)
                0: begin
                    out_ch.ready <= 1'b1;
                end
                1: begin
                    out_ch.ready <= ($urandom_range(0, 1) == 0);
                end
                2: begin
                    out_ch.ready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    out_ch.ready <= ((stall_left % 8) < 2);
                end
            endcase
        end
    end

    function automatic t_trit pick_trit_field();
        if ($urandom_range(0, 7) == 0) begin
            return TRIT_OVER;
        end
        return t_trit'($urandom_range(0, 2));
    endfunction

    // Mostly small counters, so that the sum threshold is crossed by stepping,
    // sometimes any value, sometimes values around the saturation bound.
    function automatic t_count pick_stability();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7) begin
            return t_count'($urandom_range(0, 8));
        end
        if (roll < 9) begin
            return t_count'($urandom_range(0, 255));
        end
        return t_count'($urandom_range(STAB_CAP - 3, 255));
    endfunction

    // Sends one word. The sender works in bursts; valid only drops during the
    // gap between two bursts, so back-to-back words keep valid high.
    task automatic drive_word(input t_in_word w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        @(negedge i_clk);
        in_ch.valid          <= 1'b1;
        in_ch.cmd            <= w.cmd;
        in_ch.dim_index      <= w.dim_index;
        in_ch.load_data      <= w.load_data;
        in_ch.load_mode      <= w.load_mode;
        in_ch.load_route     <= w.load_route;
        in_ch.load_role      <= w.load_role;
        in_ch.load_stability <= w.load_stability;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        // Loads aimed at the missing fourth dimension are dropped by the block.
        if (!(w.cmd == CMD_LOAD && w.dim_index == NO_DIM)) begin
            words_sent++;
        end
    endtask

    task automatic push_load(input t_dim dim, input t_trit d, input t_trit m, input t_trit r,
                             input t_trit role, input t_count stab);
        t_in_word w;
        w.cmd            = CMD_LOAD;
        w.dim_index      = dim;
        w.load_data      = d;
        w.load_mode      = m;
        w.load_route     = r;
        w.load_role      = role;
        w.load_stability = stab;
        drive_word(w);
    endtask

    // The load fields of a step word carry random junk; the block ignores them.
    task automatic push_step();
        t_in_word w;
        w                = t_in_word'($urandom());
        w.cmd            = CMD_STEP;
        drive_word(w);
    endtask

    // Stops sending until every step already accepted has produced its result.
    task automatic hold_until_drained();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (results_due != 0) begin
            @(negedge i_clk);
        end
        burst_left = 0;
    endtask

    task automatic run_directed_words();
        // A step from the reset state: roles in index order, all trits zero.
        push_step();
        // Boundary loads: out-of-range trits saturate, a load of the fourth
        // dimension is dropped, an out-of-range role becomes coordinator.
        push_load(2'd0, 2'd2, 2'd1, 2'd0, ROLE_CTRL, 8'd0);
        push_load(2'd1, TRIT_OVER, TRIT_OVER, TRIT_OVER, ROLE_DATA, 8'd255);
        push_load(NO_DIM, TRIT_OVER, TRIT_OVER, TRIT_OVER, TRIT_OVER, 8'd255);
        push_step();
        push_load(2'd2, 2'd1, 2'd0, 2'd2, TRIT_OVER, 8'd7);
        push_step();
        // Settled fields with zero counters keep the loaded roles for the step.
        // First no control dimension and two data dimensions.
        push_load(2'd0, 2'd0, 2'd0, 2'd0, ROLE_DATA, 8'd0);
        push_load(2'd1, 2'd0, 2'd0, 2'd0, ROLE_DATA, 8'd0);
        push_load(2'd2, 2'd0, 2'd0, 2'd0, ROLE_COORD, 8'd0);
        push_step();
        // Only coordinators: no mode and no data trit is written.
        push_load(2'd0, 2'd1, 2'd1, 2'd1, ROLE_COORD, 8'd0);
        push_load(2'd1, 2'd1, 2'd1, 2'd1, ROLE_COORD, 8'd0);
        push_load(2'd2, 2'd1, 2'd1, 2'd1, ROLE_COORD, 8'd0);
        push_step();
        // No coordinator: the first pair is active and no route is written.
        push_load(2'd0, 2'd2, 2'd2, 2'd2, ROLE_CTRL, 8'd1);
        push_load(2'd1, 2'd2, 2'd2, 2'd2, ROLE_CTRL, 8'd1);
        push_load(2'd2, 2'd2, 2'd2, 2'd2, ROLE_DATA, 8'd1);
        push_step();
        // All-ones fields with roles in index order stay settled, so the
        // counters climb into the bound while one loaded above it holds still.
        push_load(2'd0, 2'd1, 2'd1, 2'd1, ROLE_CTRL, t_count'(STAB_CAP - 2));
        push_load(2'd1, 2'd1, 2'd1, 2'd1, ROLE_DATA, t_count'(STAB_CAP));
        push_load(2'd2, 2'd1, 2'd1, 2'd1, ROLE_COORD, 8'd255);
        push_step();
        push_step();
        push_step();
    endtask

    task automatic run_random_words();
        int    start_count;
        int    next_pause;
        int    kind;
        int    steps;
        int    tmp;
        int    j;
        int    perm [3];
        t_trit fill;
        t_trit role;
        start_count = words_sent;
        next_pause  = $urandom_range(200, 500);
        while (words_sent - start_count < RANDOM_WORDS) begin
            if (words_sent - start_count >= next_pause) begin
                hold_until_drained();
                next_pause += $urandom_range(200, 500);
            end
            perm[0] = 0;
            perm[1] = 1;
            perm[2] = 2;
            for (int i = 2; i > 0; i--) begin
                j = $urandom_range(0, i);
                tmp = perm[i];
                perm[i] = perm[j];
                perm[j] = tmp;
            end
            kind = $urandom_range(0, 99);
            if (kind < 50) begin
                // A full reload of all dimensions, mostly with distinct roles,
                // followed by a run of steps.
                for (int d = 0; d < 3; d++) begin
                    role = ($urandom_range(0, 4) == 0) ? t_trit'($urandom_range(0, 3))
                                                       : t_trit'(perm[d]);
                    push_load(t_dim'(d), pick_trit_field(), pick_trit_field(),
                              pick_trit_field(), role, pick_stability());
                end
                steps = $urandom_range(1, 40);
            end else if (kind < 75) begin
                push_load(t_dim'($urandom_range(0, 2)), pick_trit_field(), pick_trit_field(),
                          pick_trit_field(), t_trit'($urandom_range(0, 3)), pick_stability());
                steps = $urandom_range(1, 10);
            end else if (kind < 90) begin
                // Noise: any word at all, the dropped fourth dimension included.
                steps = 0;
                repeat ($urandom_range(1, 8)) begin
                    drive_word(t_in_word'($urandom()));
                end
            end else begin
                // A settled start and a long run of steps, to drive the
                // counters through the sum threshold and toward saturation.
                fill = t_trit'($urandom_range(0, 2));
                for (int d = 0; d < 3; d++) begin
                    push_load(t_dim'(d), fill, fill, fill,
                              ($urandom_range(0, 1) == 0) ? t_trit'(d) : t_trit'(perm[d]),
                              pick_stability());
                end
                steps = $urandom_range(50, 220);
            end
            repeat (steps) begin
                push_step();
            end
        end
    endtask

    initial begin
        in_ch.valid          = 1'b0;
        in_ch.cmd            = CMD_STEP;
        in_ch.dim_index      = '0;
        in_ch.load_data      = '0;
        in_ch.load_mode      = '0;
        in_ch.load_route     = '0;
        in_ch.load_role      = '0;
        in_ch.load_stability = '0;
        i_rst_n              = 1'b0;
        repeat (11) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed_words();
        run_random_words();

        // Let every outstanding result arrive, then keep watching for anything
        // unexpected before the verdict.
        hold_until_drained();
        repeat (DRAIN_CYCLES) begin
            @(posedge i_clk);
        end
        if (fail_total == 0 && results_due == 0) begin
            $display("tb_ternary_role_step_machine OK");
        end else begin
            $display("tb_ternary_role_step_machine NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/trsm_pkg.sv
rtl/trsm_if.sv
rtl/ternary_role_step_machine.sv
rtl/trsm_checker.sv
tb/trsm_step_checker.sv
tb/tb_ternary_role_step_machine.sv
